// ===== sv/srle_pkg.sv =====
// Shared types and constants for the screen RLE run expander.
package srle_pkg;

  localparam int unsigned MAX_DIM_BITS_DEFAULT = 12;
  localparam int unsigned QUEUE_DEPTH          = 2;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned COLOUR_W    = 24;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned RUN_W       = 32;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [OP_W-1:0] OP_TOKEN = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_EOP   = 2'd2;

  localparam logic [CODE_W-1:0] LONG_RUN_CODE = 8'd0;
  localparam logic [CODE_W-1:0] COPY_CODE     = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [COLOUR_W-1:0] fill_colour;
    logic [CODE_W-1:0]   run_code;
    logic [RUN_W-1:0]    long_run;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pixel_row;
    logic [COORD_W-1:0]  pixel_col;
    logic [COLOUR_W-1:0] pixel_value;
    logic                copy_from_reference;
    logic                frame_done;
    logic                intra_frame;
    logic                error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TOKEN,
    CMD_TICK,
    CMD_EOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [RUN_W-1:0]    len;
    logic [COLOUR_W-1:0] colour;
    logic                copy;
  } cmd_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

// ===== sv/srle_fifo.sv =====
// Small register queue used between the front, the back and the result port.
module srle_fifo import srle_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/srle_front.sv =====
// Front end: takes input items and turns them into commands for the back end.
module srle_front import srle_pkg::*; (
  input  in_item_t item,
  input  logic     push,
  output logic     full,
  input  logic     cmd_full,
  output logic     cmd_push,
  output cmd_t     cmd
);

  logic is_copy;

  assign full    = cmd_full;
  assign is_copy = (item.run_code == COPY_CODE);

  always_comb begin
    cmd.kind   = CMD_TICK;
    cmd.copy   = is_copy;
    cmd.colour = is_copy ? '0 : item.fill_colour;
    priority if (item.run_code == LONG_RUN_CODE) begin
      cmd.len = item.long_run;
    end else if (is_copy) begin
      cmd.len = RUN_W'(item.fill_colour);
    end else begin
      cmd.len = RUN_W'(item.run_code);
    end
    cmd_push = push && !cmd_full;
    unique case (item.op)
      OP_TOKEN: cmd.kind = CMD_TOKEN;
      OP_TICK:  cmd.kind = CMD_TICK;
      OP_EOP:   cmd.kind = CMD_EOP;
      default:  cmd_push = 1'b0;
    endcase
  end

endmodule

// ===== sv/srle_back.sv =====
// Back end: run counters, frame position, packet flags and frame size registers.
module srle_back import srle_pkg::*; #(
  parameter int unsigned MAX_DIM_BITS = MAX_DIM_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_wr_t   cfg_wr,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  localparam int unsigned DIM_W  = MAX_DIM_BITS + 1;
  localparam int unsigned CMPD_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int unsigned PIX_W  = 2 * DIM_W;
  localparam int unsigned CMP_W  = (PIX_W > RUN_W) ? PIX_W : RUN_W;
  localparam int unsigned EXT_W  = (MAX_DIM_BITS > COORD_W) ? MAX_DIM_BITS : COORD_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
    logic [CMPD_W-1:0] ve;
    logic [CMPD_W-1:0] lim;
    ve  = CMPD_W'(v);
    lim = CMPD_W'(1) << MAX_DIM_BITS;
    if (v == '0) begin
      return DIM_W'(1);
    end else if (ve > lim) begin
      return DIM_W'(lim);
    end
    return DIM_W'(ve);
  endfunction

  logic [CFG_DATA_W-1:0]   frame_width;
  logic [CFG_DATA_W-1:0]   frame_height;
  logic [PIX_W-1:0]        frame_pixels;
  logic [PIX_W-1:0]        pix_done;
  logic [RUN_W-1:0]        run_left;
  logic [MAX_DIM_BITS-1:0] cur_col;
  logic [MAX_DIM_BITS-1:0] cur_row;
  logic [COLOUR_W-1:0]     run_colour;
  logic                    run_is_copy;
  logic                    intra_seen;
  logic                    error_seen;

  logic [DIM_W-1:0]        eff_w;
  logic [DIM_W-1:0]        eff_h;
  logic [DIM_W-1:0]        restart_h;
  logic [PIX_W-1:0]        pix_left;
  logic                    cfg_hit;
  logic                    run_busy;
  logic                    last_col;
  logic                    token_over;
  logic [EXT_W-1:0]        row_ext;
  logic [EXT_W-1:0]        col_ext;

  assign eff_w     = eff_dim(frame_width);
  assign eff_h     = eff_dim(frame_height);
  assign pix_left  = frame_pixels - pix_done;
  assign run_busy  = (run_left != '0);
  assign last_col  = ({1'b0, cur_col} + DIM_W'(1)) == eff_w;
  assign token_over = CMP_W'(cmd.len) > CMP_W'(pix_left);
  assign cfg_hit   = cfg_wr.we &&
                     (cfg_wr.index == CFG_FRAME_WIDTH || cfg_wr.index == CFG_FRAME_HEIGHT);
  assign restart_h = (cfg_hit && cfg_wr.index == CFG_FRAME_HEIGHT) ?
                     eff_dim(cfg_wr.data) : eff_h;

  assign cmd_pop = !cmd_empty && !res_full;
  assign row_ext = EXT_W'(cur_row);
  assign col_ext = EXT_W'(cur_col);

  always_comb begin
    res      = '0;
    res_push = 1'b0;
    if (cmd_pop) begin
      unique case (cmd.kind)
        CMD_TICK: begin
          res_push                = run_busy;
          res.pixel_row           = row_ext[COORD_W-1:0];
          res.pixel_col           = col_ext[COORD_W-1:0];
          res.pixel_value         = run_colour;
          res.copy_from_reference = run_is_copy;
        end
        CMD_EOP: begin
          res_push        = 1'b1;
          res.frame_done  = 1'b1;
          res.intra_frame = intra_seen;
          res.error       = error_seen;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    frame_pixels <= PIX_W'(eff_w) * PIX_W'(eff_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      pix_done     <= '0;
      run_left     <= '0;
      cur_col      <= '0;
      cur_row      <= MAX_DIM_BITS'(eff_dim(FRAME_HEIGHT_RESET) - DIM_W'(1));
      run_colour   <= '0;
      run_is_copy  <= 1'b0;
      intra_seen   <= 1'b1;
      error_seen   <= 1'b0;
    end else if (cfg_hit || (cmd_pop && cmd.kind == CMD_EOP)) begin
      if (cfg_hit && cfg_wr.index == CFG_FRAME_WIDTH) begin
        frame_width <= cfg_wr.data;
      end
      if (cfg_hit && cfg_wr.index == CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_wr.data;
      end
      pix_done    <= '0;
      run_left    <= '0;
      cur_col     <= '0;
      cur_row     <= MAX_DIM_BITS'(restart_h - DIM_W'(1));
      run_colour  <= '0;
      run_is_copy <= 1'b0;
      intra_seen  <= 1'b1;
      error_seen  <= 1'b0;
    end else if (cmd_pop) begin
      unique case (cmd.kind)
        CMD_TOKEN: begin
          if (!run_busy && !error_seen) begin
            if (token_over) begin
              error_seen <= 1'b1;
            end else begin
              run_left    <= cmd.len;
              run_is_copy <= cmd.copy;
              run_colour  <= cmd.colour;
              if (cmd.copy) begin
                intra_seen <= 1'b0;
              end
            end
          end
        end
        CMD_TICK: begin
          if (run_busy) begin
            run_left <= run_left - RUN_W'(1);
            pix_done <= pix_done + PIX_W'(1);
            if (last_col) begin
              cur_col <= '0;
              if (cur_row != '0) begin
                cur_row <= cur_row - MAX_DIM_BITS'(1);
              end
            end else begin
              cur_col <= cur_col + MAX_DIM_BITS'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    run_busy |-> CMP_W'(run_left) <= CMP_W'(pix_left))
    else $error("pending run exceeds pixels left in frame");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> {1'b0, cur_col} < eff_w)
    else $error("column outside frame width");

  a_eop_restart: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.kind == CMD_EOP |=> !run_busy && intra_seen && !error_seen)
    else $error("packet state not restarted after end of packet");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen && !cfg_hit && !(cmd_pop && cmd.kind == CMD_EOP) |=> error_seen)
    else $error("error flag cleared inside packet");

endmodule

// ===== sv/screen_rle_run_expander.sv =====
// Top level of the screen RLE run expander: front, command queue, back, result queue.
// Each item is registered in the command queue, its result in the result queue.
// Throughput: one item per cycle unless the command queue is full; the back end runs one
// command per cycle, held off while the result queue is full. Both queues are two deep.
// Synchronous active-high reset empties the queues, sets the frame to 640 x 480
// and restarts the packet state; configuration writes are always ready.
module screen_rle_run_expander import srle_pkg::*; #(
  parameter int unsigned MAX_DIM_BITS = MAX_DIM_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               item,
  input  logic                   push,
  output logic                   full,
  output out_item_t              result,
  output logic                   empty,
  input  logic                   pop,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t      front_cmd;
  logic      front_push;
  cmd_t      back_cmd;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t back_res;
  logic      res_push;
  logic      res_full;
  cfg_wr_t   cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  srle_front u_front (
    .item     (item),
    .push     (push),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  srle_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  srle_back #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  srle_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the screen RLE run expander: random runs, frame sizes and stalls.
`timescale 1ns / 100ps

module testbench;
  import srle_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 4'hF;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  in_item_t               item = '0;
  logic                   push = 1'b0;
  logic                   full;
  out_item_t              result;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  screen_rle_run_expander u_dut (
    .clk(clk), .rst(rst),
    .item(item), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expander model state
  logic [CFG_DATA_W-1:0] width_reg, height_reg;
  logic [31:0]           run_remaining;
  logic [COORD_W-1:0]    col_pos, row_pos;
  logic [COLOUR_W-1:0]   run_fill;
  logic                  run_copies, no_copy_yet, overrun_seen, frame_filled;

  out_item_t   expected_writes[$];
  in_item_t    item_backlog[$];
  out_item_t   next_write;
  int unsigned fail_count = 0;
  int unsigned items_in = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  logic        item_taken = 1'b0;

  // stimulus-side view of the frame
  logic [CFG_DATA_W-1:0] gen_width = FRAME_WIDTH_RESET;
  logic [CFG_DATA_W-1:0] gen_height = FRAME_HEIGHT_RESET;
  longint unsigned       gen_space;

  function automatic int unsigned dim_of(input logic [CFG_DATA_W-1:0] v);
    int unsigned lim = 1 << MAX_DIM_BITS_DEFAULT;
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic longint unsigned frame_pixels();
    return longint'(dim_of(gen_width)) * dim_of(gen_height);
  endfunction

  function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                         input logic [COLOUR_W-1:0] colour,
                                         input logic [CODE_W-1:0] code,
                                         input logic [RUN_W-1:0] lr);
    in_item_t it;
    it.op = op;
    it.fill_colour = colour;
    it.run_code = code;
    it.long_run = lr;
    return it;
  endfunction

  task restart_packet();
    run_remaining = '0;
    col_pos = '0;
    row_pos = COORD_W'(dim_of(height_reg) - 1);
    run_fill = '0;
    run_copies = 1'b0;
    no_copy_yet = 1'b1;
    overrun_seen = 1'b0;
    frame_filled = 1'b0;
  endtask

  function automatic longint unsigned room_left();
    int unsigned w = dim_of(width_reg);
    if (frame_filled) return 0;
    return 64'(row_pos) * w + (w - col_pos);
  endfunction

  task apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) width_reg = val;
    else if (idx == CFG_FRAME_HEIGHT) height_reg = val;
    else return;
    restart_packet();
  endtask

  task expand_item(input in_item_t it);
    logic [31:0] len;
    int unsigned w;
    out_item_t   r;
    r = '0;
    w = dim_of(width_reg);
    case (it.op)
      OP_TOKEN: begin
        if (run_remaining == 0 && !overrun_seen) begin
          if (it.run_code == LONG_RUN_CODE) len = it.long_run;
          else if (it.run_code == COPY_CODE) len = {8'd0, it.fill_colour};
          else len = {24'd0, it.run_code};
          if (64'(len) > room_left()) begin
            overrun_seen = 1'b1;
          end else begin
            run_remaining = len;
            run_copies = (it.run_code == COPY_CODE);
            run_fill = run_copies ? '0 : it.fill_colour;
            if (run_copies) no_copy_yet = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (run_remaining != 0 && !frame_filled) begin
          r.pixel_row = row_pos;
          r.pixel_col = col_pos;
          r.pixel_value = run_fill;
          r.copy_from_reference = run_copies;
          expected_writes.push_back(r);
          run_remaining = run_remaining - 1;
          if (32'(col_pos) + 1 >= w) begin
            col_pos = '0;
            if (row_pos == 0) frame_filled = 1'b1;
            else row_pos = row_pos - 1;
          end else begin
            col_pos = col_pos + 1;
          end
        end
      end
      OP_EOP: begin
        r.frame_done = 1'b1;
        r.intra_frame = no_copy_yet;
        r.error = overrun_seen;
        expected_writes.push_back(r);
        restart_packet();
      end
      default: ;
    endcase
  endtask

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  // scoreboard, model update and watchdog
  always @(posedge clk) begin
    if (rst) begin
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      restart_packet();
      item_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_writes.size() == 0) begin
          $error("result transfer with no expectation: row %0d col %0d done %0b",
                 result.pixel_row, result.pixel_col, result.frame_done);
          fail_count++;
        end else begin
          next_write = expected_writes.pop_front();
          check_field("pixel_row", next_write.pixel_row, result.pixel_row);
          check_field("pixel_col", next_write.pixel_col, result.pixel_col);
          check_field("pixel_value", next_write.pixel_value, result.pixel_value);
          check_field("copy_from_reference", next_write.copy_from_reference,
                      result.copy_from_reference);
          check_field("frame_done", next_write.frame_done, result.frame_done);
          check_field("intra_frame", next_write.intra_frame, result.intra_frame);
          check_field("error", next_write.error, result.error);
        end
      end
      if (push && !full) begin
        expand_item(item);
        items_in <= items_in + 1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        cfg_writes <= cfg_writes + 1;
      end
      item_taken <= push && !full;
      if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL screen_rle_run_expander");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // sender: bursts with gaps
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        push <= 1'b1;
        item <= item_backlog.pop_front();
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left <= $urandom_range(40, 120);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= $urandom_range(1, 8);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int unsigned hold_left = 0;
  bit          hold_armed = 1'b1;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && items_in >= 500 && push) begin
      hold_armed <= 1'b0;
      hold_left <= 400;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ~pop;
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) gen_width = val;
    else if (idx == CFG_FRAME_HEIGHT) gen_height = val;
    if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) gen_space = frame_pixels();
  endtask

  task automatic settle();
    while (item_backlog.size() != 0 || push || expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_items(input int budget, input bit close_packet);
    int          made;
    int          pick;
    int unsigned roll;
    int unsigned len;
    int unsigned k;
    logic [31:0] lr;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (gen_space == 0 && pick < 50) pick = 10;
      if (pick < 8) begin
        item_backlog.push_back(make_item(OP_W'($urandom_range(0, 3)), COLOUR_W'($urandom),
                                         CODE_W'($urandom), $urandom));
        made++;
      end else if (pick < 12) begin
        item_backlog.push_back(make_item(OP_EOP, COLOUR_W'($urandom), CODE_W'($urandom),
                                         $urandom));
        gen_space = frame_pixels();
        made++;
      end else if (pick < 16) begin
        // overrun, then a packet that is dead until its end
        lr = $urandom;
        if (64'(lr) <= gen_space) lr = 32'(gen_space + 1);
        item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom), LONG_RUN_CODE, lr));
        if ($urandom_range(0, 1) == 1)
          item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom),
                                           CODE_W'($urandom_range(1, 254)), $urandom));
        item_backlog.push_back(make_item(OP_TICK, COLOUR_W'($urandom), CODE_W'($urandom),
                                         $urandom));
        item_backlog.push_back(make_item(OP_EOP, '0, '0, '0));
        gen_space = frame_pixels();
        made += 4;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) len = 0;
        else if (roll < 90) len = $urandom_range(1, 8);
        else if (roll < 97) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 254);
        if (len > gen_space) len = 32'(gen_space);
        case ($urandom_range(0, 2))
          0: item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom), LONG_RUN_CODE, len));
          1: item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'(len), COPY_CODE, $urandom));
          default: begin
            if (len >= 1 && len <= 254)
              item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom), CODE_W'(len),
                                               $urandom));
            else
              item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom), LONG_RUN_CODE,
                                               len));
          end
        endcase
        made++;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            item_backlog.push_back(make_item(OP_TOKEN, COLOUR_W'($urandom), CODE_W'($urandom),
                                             $urandom));
            made++;
          end
          item_backlog.push_back(make_item(OP_TICK, COLOUR_W'($urandom), CODE_W'($urandom),
                                           $urandom));
          made++;
        end
        if ($urandom_range(0, 9) == 0) begin
          item_backlog.push_back(make_item(OP_TICK, COLOUR_W'($urandom), CODE_W'($urandom),
                                           $urandom));
          made++;
        end
        gen_space = gen_space - len;
      end
    end
    if (close_packet) begin
      item_backlog.push_back(make_item(OP_EOP, '0, '0, '0));
      gen_space = frame_pixels();
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input bit close_packet);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    queue_random_items(PHASE_ITEMS, close_packet);
    settle();
  endtask

  initial begin
    gen_space = frame_pixels();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset frame size
    item_backlog.push_back(make_item(OP_EOP, '0, '0, '0));
    item_backlog.push_back(make_item(OP_TICK, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF));
    item_backlog.push_back(make_item(OP_UNUSED, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF));
    item_backlog.push_back(make_item(OP_TOKEN, 24'hFFFFFF, 8'd3, 32'hFFFFFFFF));
    repeat (4) item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    item_backlog.push_back(make_item(OP_TOKEN, 24'h000000, 8'd1, '0));
    item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    item_backlog.push_back(make_item(OP_TOKEN, 24'h123456, LONG_RUN_CODE, 32'd2));
    // token while a run is pending
    item_backlog.push_back(make_item(OP_TOKEN, 24'hABCDEF, 8'd5, '0));
    repeat (2) item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    // zero-length runs, the copy one clearing intra
    item_backlog.push_back(make_item(OP_TOKEN, 24'h777777, LONG_RUN_CODE, 32'd0));
    item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    item_backlog.push_back(make_item(OP_TOKEN, 24'd0, COPY_CODE, '0));
    item_backlog.push_back(make_item(OP_TOKEN, 24'd2, COPY_CODE, '0));
    repeat (2) item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    item_backlog.push_back(make_item(OP_EOP, '0, '0, '0));
    // copy overrun keeps intra; later tokens ignored
    item_backlog.push_back(make_item(OP_TOKEN, 24'hFFFFFF, COPY_CODE, '0));
    item_backlog.push_back(make_item(OP_TOKEN, '0, LONG_RUN_CODE, 32'hFFFFFFFF));
    item_backlog.push_back(make_item(OP_TICK, '0, '0, '0));
    item_backlog.push_back(make_item(OP_EOP, '0, '0, '0));
    settle();

    run_phase(13'd4, 13'd3, 1'b1);
    run_phase(13'd1, 13'd1, 1'b1);
    run_phase(13'd0, 13'd0, 1'b1);
    run_phase(13'd8191, 13'd2, 1'b1);
    run_phase(13'd3, 13'd8191, 1'b1);
    run_phase(13'd4096, 13'd4096, 1'b1);
    // unknown register index mid-packet must leave the packet alone
    run_phase(13'd13, 13'd7, 1'b0);
    write_reg(CFG_NONE, CFG_DATA_W'($urandom));
    queue_random_items(PHASE_ITEMS, 1'b1);
    settle();
    run_phase(13'd2, 13'd4097, 1'b1);
    run_phase(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET, 1'b1);

    if (fail_count == 0) begin
      $display("PASS screen_rle_run_expander");
    end else begin
      $display("FAIL screen_rle_run_expander");
    end
    $finish;
  end

endmodule
